FILE: src/wpsp_pkg.sv
// Shared types and constants for the WAVE PCM stream parser.
// Holds the transaction structs, result and error codes, and position constants.
// Depends on nothing.
package wpsp_pkg;

   localparam int SEARCH_WINDOW = 256;

   localparam int FMT_BASE    = 'h14;
   localparam int FMT_LAST    = 'h23;
   localparam int TAG_MIN_END = 'h1F;
   localparam int RIFF_END    = 3;

   localparam int POS_LIMIT = (SEARCH_WINDOW > FMT_LAST + 1) ? SEARCH_WINDOW : FMT_LAST + 1;
   localparam int POS_W     = $clog2(POS_LIMIT + 1);

   typedef logic [POS_W-1:0] pos_type;

   localparam pos_type POS_RIFF_END    = pos_type'(RIFF_END);
   localparam pos_type POS_TAG_0       = pos_type'(FMT_BASE);
   localparam pos_type POS_TAG_1       = pos_type'(FMT_BASE + 1);
   localparam pos_type POS_CHAN_0      = pos_type'(FMT_BASE + 2);
   localparam pos_type POS_CHAN_1      = pos_type'(FMT_BASE + 3);
   localparam pos_type POS_RATE_0      = pos_type'(FMT_BASE + 4);
   localparam pos_type POS_RATE_1      = pos_type'(FMT_BASE + 5);
   localparam pos_type POS_RATE_2      = pos_type'(FMT_BASE + 6);
   localparam pos_type POS_RATE_3      = pos_type'(FMT_BASE + 7);
   localparam pos_type POS_BITS_0      = pos_type'(FMT_BASE + 14);
   localparam pos_type POS_BITS_1      = pos_type'(FMT_LAST);
   localparam pos_type POS_FMT_LAST    = pos_type'(FMT_LAST);
   localparam pos_type POS_TAG_MIN_END = pos_type'(TAG_MIN_END);
   localparam pos_type POS_SEARCH_LAST = pos_type'(SEARCH_WINDOW - 1);
   localparam pos_type POS_SEARCH_END  = pos_type'(SEARCH_WINDOW);
   localparam pos_type POS_MAX         = pos_type'(POS_LIMIT);

   localparam logic [31:0] RIFF_WORD  = 32'h4646_4952;
   localparam logic [31:0] DATA_TAG   = 32'h6174_6164;
   localparam logic [7:0]  TAG_FIRST  = 8'h64;
   localparam logic [7:0]  SIGN_FLIP  = 8'h80;
   localparam logic [15:0] PCM_TAG    = 16'h0001;
   localparam logic [15:0] CHAN_MONO  = 16'd1;
   localparam logic [15:0] CHAN_STEREO = 16'd2;
   localparam logic [15:0] BITS_NARROW = 16'd8;
   localparam logic [15:0] BITS_WIDE  = 16'd16;

   typedef enum logic [1:0] {
      KIND_FRAME,
      KIND_HEADER,
      KIND_ERROR,
      KIND_END
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE,
      ERR_NOT_RIFF,
      ERR_NOT_PCM,
      ERR_CHANNELS,
      ERR_BITS,
      ERR_NO_DATA,
      ERR_SIZE_ZERO
   } err_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_file;
   } req_item_type;

   typedef struct packed {
      kind_type           kind;
      logic signed [15:0] left_sample;
      logic signed [15:0] right_sample;
      err_type            error_code;
      logic [31:0]        sample_rate;
      logic [31:0]        total_frames;
      logic               last;
   } rsp_item_type;

endpackage

FILE: src/wav_pcm_stream_parser.sv
// The parser takes one byte of a RIFF WAVE file per cycle and returns at most one result
// per byte through a two-entry output buffer, which registers each result. A byte is
// accepted in every cycle as long as the buffer has room; req_stall rises only when both
// buffer entries hold results that the consumer has not yet taken. There is no clearing
// pass after reset, and the parser core returns to its reset state after every byte that
// is marked as the end of the file. Top level; depends on wpsp_pkg, wpsp_parser and
// wpsp_out_buffer.
module wav_pcm_stream_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  wpsp_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output wpsp_pkg::rsp_item_type rsp_item
);

   logic                   accept;
   logic                   res_valid;
   wpsp_pkg::rsp_item_type res_item;
   logic                   full;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   wpsp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .item      (req_item),
      .res_valid (res_valid),
      .res_item  (res_item)
   );

   wpsp_out_buffer u_out_buffer (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_item (res_item),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

FILE: src/wpsp_parser.sv
// Parser core: header checks, data tag search, size capture and frame assembly.
// Updates its state on each accepted byte and forms at most one result per byte.
// Depends on wpsp_pkg.
module wpsp_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  wpsp_pkg::req_item_type item,
   output logic                   res_valid,
   output wpsp_pkg::rsp_item_type res_item
);

   typedef enum logic [1:0] {
      PH_HEAD,
      PH_SIZE,
      PH_DATA,
      PH_DEAD
   } phase_type;

   phase_type         phase_ff, phase_in;
   wpsp_pkg::pos_type pos_ff, pos_in;
   logic [15:0]       fmt_tag_ff, fmt_tag_in;
   logic [15:0]       chan_ff, chan_in;
   logic [15:0]       bits_ff, bits_in;
   logic [31:0]       rate_ff, rate_in;
   logic [31:0]       len_ff, len_in;
   logic [23:0]       asm_ff, asm_in;
   logic [1:0]        match_ff, match_in;
   logic [1:0]        idx_ff, idx_in;
   logic              riff_bad_ff, riff_bad_in;
   logic              missing_ff, missing_in;

   logic              res_hit;
   logic [7:0]        b;
   logic              eof;
   logic              stereo;
   logic              wide;
   logic              frame_done;
   logic [7:0]        a0, a1, a2;
   logic              hit;
   logic              found;
   logic              size_done;
   logic              header;
   logic [1:0]        shift;
   wpsp_pkg::err_type err;

   assign b      = item.data_byte;
   assign eof    = item.end_of_file;
   assign stereo = (chan_ff == wpsp_pkg::CHAN_STEREO);
   assign wide   = (bits_ff == wpsp_pkg::BITS_WIDE);
   assign a0     = (idx_ff == 2'd0) ? b : asm_ff[7:0];
   assign a1     = (idx_ff == 2'd1) ? b : asm_ff[15:8];
   assign a2     = (idx_ff == 2'd2) ? b : asm_ff[23:16];
   assign frame_done = (stereo && wide) ? (idx_ff == 2'd3) :
                       (stereo || wide) ? (idx_ff == 2'd1) : (idx_ff == 2'd0);
   assign hit    = (b == wpsp_pkg::DATA_TAG[{match_ff, 3'b000} +: 8]);
   assign found  = hit && (&match_ff);
   assign res_valid = accept && res_hit;

   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      fmt_tag_in  = fmt_tag_ff;
      chan_in     = chan_ff;
      bits_in     = bits_ff;
      rate_in     = rate_ff;
      len_in      = len_ff;
      asm_in      = asm_ff;
      match_in    = match_ff;
      idx_in      = idx_ff;
      riff_bad_in = riff_bad_ff;
      missing_in  = missing_ff;
      res_hit     = 1'b0;
      res_item    = '0;
      err         = wpsp_pkg::ERR_NONE;
      size_done   = 1'b0;
      header      = 1'b0;
      shift       = '0;

      unique case (phase_ff)
         PH_DEAD: begin
            res_hit = 1'b0;
         end
         PH_DATA: begin
            asm_in = {a2, a1, a0};
            if (frame_done) begin
               res_hit           = 1'b1;
               res_item.kind     = wpsp_pkg::KIND_FRAME;
               res_item.left_sample = wide ? {a1, a0} : {a0 ^ wpsp_pkg::SIGN_FLIP, 8'h00};
               if (stereo) begin
                  res_item.right_sample = wide ? {b, a2} : {a1 ^ wpsp_pkg::SIGN_FLIP, 8'h00};
               end else begin
                  res_item.right_sample = res_item.left_sample;
               end
               res_item.last = eof;
               idx_in        = 2'd0;
               asm_in        = '0;
            end else begin
               idx_in = idx_ff + 2'd1;
               if (eof) begin
                  res_hit       = 1'b1;
                  res_item.kind = wpsp_pkg::KIND_END;
                  res_item.last = 1'b1;
               end
            end
         end
         PH_HEAD, PH_SIZE: begin
            if (pos_ff <= wpsp_pkg::POS_RIFF_END &&
                b != wpsp_pkg::RIFF_WORD[{pos_ff[1:0], 3'b000} +: 8]) begin
               riff_bad_in = 1'b1;
            end

            unique case (pos_ff)
               wpsp_pkg::POS_TAG_0:  fmt_tag_in[7:0]  = b;
               wpsp_pkg::POS_TAG_1:  fmt_tag_in[15:8] = b;
               wpsp_pkg::POS_CHAN_0: chan_in[7:0]     = b;
               wpsp_pkg::POS_CHAN_1: chan_in[15:8]    = b;
               wpsp_pkg::POS_RATE_0: rate_in[7:0]     = b;
               wpsp_pkg::POS_RATE_1: rate_in[15:8]    = b;
               wpsp_pkg::POS_RATE_2: rate_in[23:16]   = b;
               wpsp_pkg::POS_RATE_3: rate_in[31:24]   = b;
               wpsp_pkg::POS_BITS_0: bits_in[7:0]     = b;
               wpsp_pkg::POS_BITS_1: bits_in[15:8]    = b;
               default:              rate_in          = rate_ff;
            endcase

            if (phase_ff == PH_SIZE) begin
               len_in[{idx_ff, 3'b000} +: 8] = b;
               if (&idx_ff) begin
                  size_done = 1'b1;
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
            end else begin
               if (hit) begin
                  match_in = match_ff + 2'd1;
               end else begin
                  match_in = (b == wpsp_pkg::TAG_FIRST) ? 2'd1 : 2'd0;
               end
               if (found && pos_ff < wpsp_pkg::POS_SEARCH_END &&
                   pos_ff >= wpsp_pkg::POS_TAG_MIN_END) begin
                  phase_in = PH_SIZE;
                  idx_in   = 2'd0;
               end
               if (phase_in == PH_HEAD && pos_ff >= wpsp_pkg::POS_SEARCH_LAST) begin
                  missing_in = 1'b1;
               end
            end

            if (pos_ff == wpsp_pkg::POS_RIFF_END && riff_bad_in) begin
               err = wpsp_pkg::ERR_NOT_RIFF;
            end else if (pos_ff == wpsp_pkg::POS_FMT_LAST) begin
               if (fmt_tag_in != wpsp_pkg::PCM_TAG) begin
                  err = wpsp_pkg::ERR_NOT_PCM;
               end else if (chan_in != wpsp_pkg::CHAN_MONO &&
                            chan_in != wpsp_pkg::CHAN_STEREO) begin
                  err = wpsp_pkg::ERR_CHANNELS;
               end else if (bits_in != wpsp_pkg::BITS_NARROW &&
                            bits_in != wpsp_pkg::BITS_WIDE) begin
                  err = wpsp_pkg::ERR_BITS;
               end
            end
            if (err == wpsp_pkg::ERR_NONE && missing_in &&
                pos_ff >= wpsp_pkg::POS_FMT_LAST) begin
               err = wpsp_pkg::ERR_NO_DATA;
            end
            if (err == wpsp_pkg::ERR_NONE && size_done) begin
               if (len_in == '0) begin
                  err = wpsp_pkg::ERR_SIZE_ZERO;
               end else begin
                  header = 1'b1;
               end
            end
            if (err == wpsp_pkg::ERR_NONE && !header && eof) begin
               if (pos_ff < wpsp_pkg::POS_RIFF_END) begin
                  err = wpsp_pkg::ERR_NOT_RIFF;
               end else if (pos_ff < wpsp_pkg::POS_FMT_LAST) begin
                  err = wpsp_pkg::ERR_NOT_PCM;
               end else begin
                  err = wpsp_pkg::ERR_NO_DATA;
               end
            end

            if (pos_ff != wpsp_pkg::POS_MAX) begin
               pos_in = pos_ff + wpsp_pkg::pos_type'(1);
            end

            if (err != wpsp_pkg::ERR_NONE) begin
               res_hit             = 1'b1;
               res_item.kind       = wpsp_pkg::KIND_ERROR;
               res_item.error_code = err;
               res_item.last       = 1'b1;
               phase_in            = PH_DEAD;
            end else if (header) begin
               shift = {1'b0, chan_in == wpsp_pkg::CHAN_STEREO} +
                       {1'b0, bits_in == wpsp_pkg::BITS_WIDE};
               res_hit               = 1'b1;
               res_item.kind         = wpsp_pkg::KIND_HEADER;
               res_item.sample_rate  = rate_in;
               res_item.total_frames = len_in >> shift;
               res_item.last         = eof;
               phase_in              = PH_DATA;
               idx_in                = 2'd0;
               asm_in                = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && eof)) begin
         phase_ff    <= PH_HEAD;
         pos_ff      <= '0;
         match_ff    <= '0;
         idx_ff      <= '0;
         riff_bad_ff <= 1'b0;
         missing_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         match_ff    <= match_in;
         idx_ff      <= idx_in;
         riff_bad_ff <= riff_bad_in;
         missing_ff  <= missing_in;
      end
      if (accept) begin
         fmt_tag_ff <= fmt_tag_in;
         chan_ff    <= chan_in;
         bits_ff    <= bits_in;
         rate_ff    <= rate_in;
         len_ff     <= len_in;
         asm_ff     <= asm_in;
      end
   end

endmodule

FILE: src/wpsp_out_buffer.sv
// Two-entry result buffer: an output register backed by a skid register.
// Lets the parser take a byte while a finished result waits to be taken.
// Depends on wpsp_pkg.
module wpsp_out_buffer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  wpsp_pkg::rsp_item_type push_item,
   output logic                   full,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output wpsp_pkg::rsp_item_type rsp_item
);

   logic                   out_valid_ff, out_valid_in;
   logic                   skid_valid_ff, skid_valid_in;
   wpsp_pkg::rsp_item_type out_item_ff, out_item_in;
   wpsp_pkg::rsp_item_type skid_item_ff, skid_item_in;
   logic                   pop;

   assign pop       = out_valid_ff && !rsp_stall;
   assign full      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_item_in   = out_item_ff;
      skid_item_in  = skid_item_ff;
      priority if (skid_valid_ff) begin
         if (pop) begin
            out_item_in   = skid_item_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_item_in  = push_item;
            out_valid_in = 1'b1;
         end else begin
            skid_item_in  = push_item;
            skid_valid_in = 1'b1;
         end
      end else begin
         out_valid_in = out_valid_ff && !pop;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_item_ff  <= out_item_in;
      skid_item_ff <= skid_item_in;
   end

endmodule

FILE: dv/wav_pcm_stream_parser_tb.sv
// Self-checking testbench for wav_pcm_stream_parser: streams directed and random WAVE files
// through the byte channel and checks every result against an in-bench parser model.
// Depends on wpsp_pkg and the wav_pcm_stream_parser RTL.
module wav_pcm_stream_parser_tb;
   import wpsp_pkg::*;

   localparam int HALF_PERIOD   = 10;
   localparam int RANDOM_BYTES  = 1750;
   localparam int IDLE_LIMIT    = 1000;
   localparam int DRAIN_CYCLES  = 20;
   localparam int PRESSURE_HOLD = 150;
   localparam int PRESSURE_AT   = 100;
   localparam logic [31:0] WAVE_WORD = 32'h4556_4157;
   localparam logic [31:0] FMT_WORD  = 32'h2074_6D66;

   typedef enum logic [1:0] {
      PARSE_HEAD,
      PARSE_SIZE,
      PARSE_DATA,
      PARSE_DEAD
   } parse_phase_type;

   typedef enum int {
      FILE_GOOD,
      FILE_BAD_RIFF,
      FILE_BAD_TAG,
      FILE_BAD_CHANNELS,
      FILE_BAD_BITS,
      FILE_NO_TAG,
      FILE_EDGE_TAG,
      FILE_PAST_WINDOW,
      FILE_SIZE_ZERO,
      FILE_OVERLAP_TAG,
      FILE_EARLY_TAG,
      FILE_TRUNCATED,
      FILE_NOISE,
      FILE_FAR_TAG
   } file_kind_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;

   req_item_type byte_queue[$];
   rsp_item_type expected_results[$];
   logic [7:0]   file_image[$];

   bit          req_fire      = 1'b0;
   bit          rsp_fire      = 1'b0;
   bit          req_no_idle   = 1'b0;
   bit          rsp_no_idle   = 1'b0;
   bit          pressure_done = 1'b0;
   int unsigned req_gap       = 0;
   int unsigned rsp_hold      = 0;
   int unsigned stuck_cycles  = 0;
   int unsigned fail_count    = 0;
   int unsigned checked_count = 0;
   int unsigned file_count    = 0;
   int unsigned kind_counts[4];
   logic [7:0]  codes_seen    = '0;

   int unsigned     stream_pos;
   parse_phase_type parse_phase;
   logic [15:0]     fmt_tag_q;
   logic [15:0]     chan_q;
   logic [15:0]     bits_q;
   logic [31:0]     rate_q;
   logic [31:0]     size_q;
   logic [23:0]     frame_q;
   int unsigned     match_len;
   int unsigned     group_idx;
   bit              riff_bad;
   bit              tag_missing;

   always #HALF_PERIOD clock = ~clock;

   wav_pcm_stream_parser i_dut (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_item,
      .rsp_valid,
      .rsp_stall,
      .rsp_item
   );

   function automatic void clear_parser();
      stream_pos  = 0;
      parse_phase = PARSE_HEAD;
      fmt_tag_q   = '0;
      chan_q      = '0;
      bits_q      = '0;
      rate_q      = '0;
      size_q      = '0;
      frame_q     = '0;
      match_len   = 0;
      group_idx   = 0;
      riff_bad    = 1'b0;
      tag_missing = 1'b0;
   endfunction

   function automatic int unsigned frame_size();
      int unsigned n;
      n = (chan_q == CHAN_STEREO) ? 2 : 1;
      return (bits_q == BITS_WIDE) ? 2 * n : n;
   endfunction

   // Returns 1 when the byte produces a result, which is then placed in res.
   function automatic bit predict_byte(input logic [7:0] b, input logic eof,
                                       output rsp_item_type res);
      int unsigned pos;
      int unsigned bpf;
      err_type     err;
      bit          header;
      bit          size_done;
      logic [15:0] l;
      logic [15:0] r;
      pos       = stream_pos;
      err       = ERR_NONE;
      header    = 1'b0;
      size_done = 1'b0;
      res       = '0;

      if (parse_phase == PARSE_DEAD) begin
         if (eof) clear_parser();
         return 1'b0;
      end

      if (parse_phase == PARSE_DATA) begin
         bpf = frame_size();
         if (group_idx < 3) frame_q[8*group_idx +: 8] = b;
         if (group_idx + 1 >= bpf) begin
            if (bits_q == BITS_NARROW) begin
               l = {frame_q[7:0] ^ SIGN_FLIP, 8'h00};
               r = (bpf == 2) ? {b ^ SIGN_FLIP, 8'h00} : l;
            end else begin
               l = {(bpf == 2) ? b : frame_q[15:8], frame_q[7:0]};
               r = (bpf == 4) ? {b, frame_q[23:16]} : l;
            end
            res.kind         = KIND_FRAME;
            res.left_sample  = l;
            res.right_sample = r;
            res.last         = eof;
            group_idx = 0;
            frame_q   = '0;
            if (eof) clear_parser();
            return 1'b1;
         end
         group_idx = (group_idx + 1) % 4;
         if (eof) begin
            res.kind = KIND_END;
            res.last = 1'b1;
            clear_parser();
            return 1'b1;
         end
         return 1'b0;
      end

      if (pos < 4 && b != RIFF_WORD[8*pos +: 8]) riff_bad = 1'b1;
      if (pos >= FMT_BASE && pos < FMT_BASE + 2) begin
         fmt_tag_q[8*(pos - FMT_BASE) +: 8] = b;
      end else if (pos >= FMT_BASE + 2 && pos < FMT_BASE + 4) begin
         chan_q[8*(pos - FMT_BASE - 2) +: 8] = b;
      end else if (pos >= FMT_BASE + 4 && pos < FMT_BASE + 8) begin
         rate_q[8*(pos - FMT_BASE - 4) +: 8] = b;
      end else if (pos >= FMT_BASE + 14 && pos <= FMT_LAST) begin
         bits_q[8*(pos - FMT_BASE - 14) +: 8] = b;
      end

      if (pos == RIFF_END && riff_bad) err = ERR_NOT_RIFF;

      if (parse_phase == PARSE_SIZE) begin
         size_q[8*group_idx +: 8] = b;
         if (group_idx == 3) size_done = 1'b1;
         else group_idx = group_idx + 1;
      end else begin
         if (b == DATA_TAG[8*(match_len % 4) +: 8]) match_len = match_len + 1;
         else match_len = (b == TAG_FIRST) ? 1 : 0;
         if (match_len >= 4) begin
            match_len = 0;
            if (pos + 1 <= SEARCH_WINDOW && pos >= TAG_MIN_END) begin
               parse_phase = PARSE_SIZE;
               group_idx   = 0;
               size_q      = '0;
            end
         end
         if (parse_phase == PARSE_HEAD && pos + 1 >= SEARCH_WINDOW) tag_missing = 1'b1;
      end

      if (err == ERR_NONE && pos == FMT_LAST) begin
         if (fmt_tag_q != PCM_TAG) err = ERR_NOT_PCM;
         else if (chan_q != CHAN_MONO && chan_q != CHAN_STEREO) err = ERR_CHANNELS;
         else if (bits_q != BITS_NARROW && bits_q != BITS_WIDE) err = ERR_BITS;
      end
      if (err == ERR_NONE && tag_missing && pos >= FMT_LAST) err = ERR_NO_DATA;
      if (err == ERR_NONE && size_done) begin
         if (size_q == 0) err = ERR_SIZE_ZERO;
         else header = 1'b1;
      end
      if (err == ERR_NONE && !header && eof) begin
         if (pos < RIFF_END) err = ERR_NOT_RIFF;
         else if (pos < FMT_LAST) err = ERR_NOT_PCM;
         else err = ERR_NO_DATA;
      end

      if (stream_pos < 'hFFFF) stream_pos = stream_pos + 1;

      if (err != ERR_NONE) begin
         res.kind       = KIND_ERROR;
         res.error_code = err;
         res.last       = 1'b1;
         parse_phase    = PARSE_DEAD;
         if (eof) clear_parser();
         return 1'b1;
      end
      if (header) begin
         res.kind         = KIND_HEADER;
         res.sample_rate  = rate_q;
         res.total_frames = size_q / frame_size();
         res.last         = eof;
         parse_phase      = PARSE_DATA;
         group_idx        = 0;
         frame_q          = '0;
         if (eof) clear_parser();
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void put_le(logic [31:0] value, int unsigned count);
      int unsigned i;
      for (i = 0; i < count; i++) file_image.push_back(value[8*i +: 8]);
   endfunction

   function automatic int unsigned flush_file();
      int unsigned  count;
      req_item_type item;
      count = file_image.size();
      while (file_image.size() > 0) begin
         item.data_byte   = file_image.pop_front();
         item.end_of_file = (file_image.size() == 0);
         byte_queue.push_back(item);
      end
      return count;
   endfunction

   function automatic logic [7:0] filler_byte(bit allow_partial_tag);
      logic [7:0] b;
      if (allow_partial_tag && $urandom_range(0, 3) == 0) return DATA_TAG[8*$urandom_range(0, 2) +: 8];
      b = 8'($urandom());
      return (b == TAG_FIRST) ? 8'h00 : b;
   endfunction

   function automatic int unsigned add_wave_file(file_kind_type kind);
      logic [15:0] fmt_tag;
      logic [15:0] chans;
      logic [15:0] bits;
      logic [31:0] riff;
      logic [31:0] size_word;
      int unsigned filler;
      int unsigned ndata;
      int unsigned start;
      int unsigned cut;
      int unsigned i;
      fmt_tag = PCM_TAG;
      chans   = $urandom_range(0, 1) ? CHAN_STEREO : CHAN_MONO;
      bits    = $urandom_range(0, 1) ? BITS_WIDE : BITS_NARROW;
      riff    = RIFF_WORD;

      if (kind == FILE_NOISE) begin
         repeat ($urandom_range(1, 60)) file_image.push_back(8'($urandom()));
         return flush_file();
      end

      case (kind)
         FILE_BAD_RIFF: riff = RIFF_WORD ^ (32'd1 << $urandom_range(0, 31));
         FILE_BAD_TAG: fmt_tag = PCM_TAG ^ 16'($urandom_range(1, 'hFFFF));
         FILE_BAD_CHANNELS: chans = $urandom_range(0, 1) ? 16'($urandom_range(3, 'hFFFF)) : 16'd0;
         FILE_BAD_BITS: begin
            do bits = 16'($urandom()); while (bits == BITS_NARROW || bits == BITS_WIDE);
         end
         default: ;
      endcase

      put_le(riff, 4);
      put_le($urandom(), 4);
      put_le(WAVE_WORD, 4);
      put_le(FMT_WORD, 4);
      put_le(32'd16, 4);
      put_le(fmt_tag, 2);
      put_le(chans, 2);
      put_le($urandom_range(0, 1) ? 32'd44100 : $urandom(), 4);
      put_le($urandom(), 4);
      put_le($urandom(), 2);
      put_le(bits, 2);

      if (kind == FILE_OVERLAP_TAG || kind == FILE_EARLY_TAG) begin
         if (kind == FILE_OVERLAP_TAG) start = TAG_MIN_END - 3;
         else start = $urandom_range(0, 1) ? 4 : TAG_MIN_END - 4;
         for (i = 0; i < 4; i++) file_image[start + i] = DATA_TAG[8*i +: 8];
      end

      case (kind)
         FILE_EDGE_TAG: filler = SEARCH_WINDOW - 40;
         FILE_PAST_WINDOW: filler = SEARCH_WINDOW - 39;
         FILE_FAR_TAG: filler = $urandom_range(40, SEARCH_WINDOW - 41);
         FILE_NO_TAG: filler = SEARCH_WINDOW;
         default: filler = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 24) : 0;
      endcase
      repeat (filler) file_image.push_back(filler_byte(kind == FILE_GOOD));

      if (kind != FILE_NO_TAG) begin
         if (kind == FILE_GOOD && $urandom_range(0, 7) == 0) file_image.push_back(TAG_FIRST);
         put_le(DATA_TAG, 4);
      end

      ndata = ($urandom_range(0, 9) == 0) ? $urandom_range(49, 160) : $urandom_range(0, 48);
      if (kind == FILE_SIZE_ZERO) size_word = '0;
      else if ($urandom_range(0, 9) < 7) size_word = ndata;
      else size_word = $urandom();
      put_le(size_word, 4);
      repeat (ndata) file_image.push_back(8'($urandom()));

      if (kind == FILE_TRUNCATED) begin
         cut = $urandom_range(1, file_image.size() - 1);
         while (file_image.size() > cut) void'(file_image.pop_back());
      end
      return flush_file();
   endfunction

   function automatic int unsigned field_check(string field, logic [31:0] want, logic [31:0] got);
      if (want === got) return 0;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      return 1;
   endfunction

   initial begin : stimulus
      int unsigned   random_bytes;
      int unsigned   file_index;
      file_kind_type kind;
      random_bytes = 0;
      clear_parser();

      put_le(8'hFF, 1);
      void'(flush_file());
      put_le(8'h00, 1);
      void'(flush_file());
      put_le(RIFF_WORD, 2);
      void'(flush_file());
      put_le(RIFF_WORD ^ 32'h8000_0000, 4);
      put_le(8'hAA, 1);
      void'(flush_file());
      put_le(RIFF_WORD, 4);
      void'(flush_file());
      put_le(RIFF_WORD, 4);
      put_le(8'h00, 1);
      void'(flush_file());

      for (file_index = 0; random_bytes < RANDOM_BYTES; file_index++) begin
         if (file_index <= FILE_FAR_TAG) kind = file_kind_type'(file_index);
         else if ($urandom_range(0, 99) < 50) kind = FILE_GOOD;
         else kind = file_kind_type'($urandom_range(1, FILE_FAR_TAG));
         random_bytes += add_wave_file(kind);
      end
      file_count = file_index + 6;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (byte_queue.size() != 0 || req_valid || expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Streamed %0d files; checked %0d frames, %0d headers, %0d errors, %0d end markers.",
               file_count, kind_counts[KIND_FRAME], kind_counts[KIND_HEADER],
               kind_counts[KIND_ERROR], kind_counts[KIND_END]);
      $display("Error codes observed (bit per code): %b, %0d mismatches.", codes_seen, fail_count);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (req_gap > 0) begin
            req_gap = req_gap - 1;
            req_valid <= 1'b0;
         end else if (byte_queue.size() > 0) begin
            req_item  <= byte_queue.pop_front();
            req_valid <= 1'b1;
            if ($urandom_range(0, 99) == 0) req_no_idle = !req_no_idle;
            req_gap = req_no_idle ? 0 : $urandom_range(0, 10);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_fire) begin
            if ($urandom_range(0, 99) == 0) rsp_no_idle = !rsp_no_idle;
            rsp_hold = rsp_no_idle ? 0 : $urandom_range(0, 10);
            if (!pressure_done && checked_count >= PRESSURE_AT) begin
               rsp_hold      = PRESSURE_HOLD;
               pressure_done = 1'b1;
            end
         end
         if (rsp_hold > 0) begin
            rsp_hold = rsp_hold - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : monitor
      rsp_item_type want;
      req_fire = !reset && req_valid && !req_stall;
      rsp_fire = !reset && rsp_valid && !rsp_stall;
      if (req_fire && predict_byte(req_item.data_byte, req_item.end_of_file, want)) begin
         expected_results.push_back(want);
      end
      if (rsp_fire) begin
         if (expected_results.size() == 0) begin
            $display("%0t: result with none expected, actual %0h", $time, rsp_item);
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            fail_count += field_check("kind", want.kind, rsp_item.kind);
            fail_count += field_check("left_sample", want.left_sample, rsp_item.left_sample);
            fail_count += field_check("right_sample", want.right_sample, rsp_item.right_sample);
            fail_count += field_check("error_code", want.error_code, rsp_item.error_code);
            fail_count += field_check("sample_rate", want.sample_rate, rsp_item.sample_rate);
            fail_count += field_check("total_frames", want.total_frames, rsp_item.total_frames);
            fail_count += field_check("last", want.last, rsp_item.last);
            kind_counts[want.kind]++;
            codes_seen[want.error_code] = 1'b1;
            checked_count++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) stuck_cycles <= 0;
      else stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transaction for %0d cycles, giving up.", $time, IDLE_LIMIT);
         $display("FAIL");
         $finish;
      end
   end

endmodule
